// ===== sv/touch_sample_average_to_pixel_top_macros.svh =====
// Assertion macros shared by the touch averaging block.
`ifndef TOUCH_SAMPLE_AVERAGE_TO_PIXEL_TOP_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_TO_PIXEL_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define TSAP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define TSAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsap_pkg.sv =====
// Shared constants, codes and controller/datapath types of the touch averaging block.
package tsap_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int MAX_SAMPLES_DEF = 16;

    localparam int MARGIN_W   = 12;
    localparam int FS_W       = 13;
    localparam int SIZE_W     = 10;
    localparam int SPR_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OP_W       = 3;

    localparam logic [FS_W-1:0]   FS_RESET     = 13'd4096;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 10'd240;
    localparam logic [SPR_W-1:0]  SPR_RESET    = 5'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_X_LEFT_MARGIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RIGHT_MARGIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TOP_MARGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BOTTOM_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_READ = 3'd7;

    // Division operations run by the shared divider, in issue order.
    localparam logic [OP_W-1:0] OP_PPX_X = 3'd0;
    localparam logic [OP_W-1:0] OP_AVG_X = 3'd1;
    localparam logic [OP_W-1:0] OP_SCL_X = 3'd2;
    localparam logic [OP_W-1:0] OP_PPX_Y = 3'd3;
    localparam logic [OP_W-1:0] OP_AVG_Y = 3'd4;
    localparam logic [OP_W-1:0] OP_SCL_Y = 3'd5;

    typedef struct packed {
        logic            accept;
        logic            div_start;
        logic            div_store;
        logic            out_load;
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic round_end;
        logic found;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/tsap_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module tsap_divider #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~diff[DIVISOR_W+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/tsap_datapath.sv =====
// Datapath: configuration registers, sample accumulators, divider operands and result registers.
`include "touch_sample_average_to_pixel_top_macros.svh"

module tsap_datapath #(
    parameter int ADC_BITS    = tsap_pkg::ADC_BITS_DEF,
    parameter int MAX_SAMPLES = tsap_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tsap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsap_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_x_pen_down,
    input  logic [ADC_BITS-1:0]              s_x_sample,
    input  logic                             s_y_pen_down,
    input  logic [ADC_BITS-1:0]              s_y_sample,
    input  tsap_pkg::dp_cmd_t                cmd,
    output tsap_pkg::dp_status_t             status,
    output logic                             m_found,
    output logic [tsap_pkg::SIZE_W-1:0]      m_x_position,
    output logic [tsap_pkg::SIZE_W-1:0]      m_y_position
);

    localparam int MARGIN_W = tsap_pkg::MARGIN_W;
    localparam int FS_W     = tsap_pkg::FS_W;
    localparam int SIZE_W   = tsap_pkg::SIZE_W;
    localparam int SPR_W    = tsap_pkg::SPR_W;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = ADC_BITS + CNT_W;
    localparam int DIV_N    = (SUM_W > FS_W) ? SUM_W : FS_W;
    localparam int DIV_M    = (CNT_W > FS_W) ? CNT_W : FS_W;
    localparam int CMP_W    = ((CNT_W > SPR_W) ? CNT_W : SPR_W) + 1;
    localparam int SPAN_W   = FS_W + 1;

    // Configuration registers.
    logic [MARGIN_W-1:0] x_left_reg, x_right_reg, y_top_reg, y_bottom_reg;
    logic [FS_W-1:0]     full_scale_reg;
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [SPR_W-1:0]    spr_reg;

    // Round state.
    logic [CNT_W-1:0] step_reg, x_count_reg, y_count_reg;
    logic [SUM_W-1:0] x_sum_reg, y_sum_reg;

    // Intermediate and result registers.
    logic [DIV_M-1:0]  ppx_reg;
    logic [DIV_N-1:0]  off_reg;
    logic [SIZE_W-1:0] x_pos_reg, y_pos_reg;
    logic              found_reg;
    logic [SIZE_W-1:0] x_out_reg, y_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_left_reg     <= '0;
            x_right_reg    <= '0;
            y_top_reg      <= '0;
            y_bottom_reg   <= '0;
            full_scale_reg <= tsap_pkg::FS_RESET;
            width_reg      <= tsap_pkg::WIDTH_RESET;
            height_reg     <= tsap_pkg::HEIGHT_RESET;
            spr_reg        <= tsap_pkg::SPR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tsap_pkg::REG_X_LEFT_MARGIN:    x_left_reg     <= cfg_wr_data[MARGIN_W-1:0];
                tsap_pkg::REG_X_RIGHT_MARGIN:   x_right_reg    <= cfg_wr_data[MARGIN_W-1:0];
                tsap_pkg::REG_Y_TOP_MARGIN:     y_top_reg      <= cfg_wr_data[MARGIN_W-1:0];
                tsap_pkg::REG_Y_BOTTOM_MARGIN:  y_bottom_reg   <= cfg_wr_data[MARGIN_W-1:0];
                tsap_pkg::REG_ADC_FULL_SCALE:   full_scale_reg <= cfg_wr_data[FS_W-1:0];
                tsap_pkg::REG_SCREEN_WIDTH:     width_reg      <= cfg_wr_data[SIZE_W-1:0];
                tsap_pkg::REG_SCREEN_HEIGHT:    height_reg     <= cfg_wr_data[SIZE_W-1:0];
                tsap_pkg::REG_SAMPLES_PER_READ: spr_reg        <= cfg_wr_data[SPR_W-1:0];
                default: ;
            endcase
        end
    end

    // A round ends when the incremented step count reaches the clamped round length.
    logic [CMP_W-1:0] step_inc, spr_ext, spr_eff;

    always_comb begin
        step_inc = CMP_W'(step_reg) + 1'b1;
        spr_ext  = CMP_W'(spr_reg);
        if (spr_ext == '0) begin
            spr_eff = CMP_W'(1);
        end else if (spr_ext > CMP_W'(MAX_SAMPLES)) begin
            spr_eff = CMP_W'(MAX_SAMPLES);
        end else begin
            spr_eff = spr_ext;
        end
    end

    assign status.round_end = (step_inc >= spr_eff);
    assign status.found     = (y_count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            x_count_reg <= '0;
            y_count_reg <= '0;
            x_sum_reg   <= '0;
            y_sum_reg   <= '0;
        end else if (cmd.out_load) begin
            step_reg    <= '0;
            x_count_reg <= '0;
            y_count_reg <= '0;
            x_sum_reg   <= '0;
            y_sum_reg   <= '0;
        end else if (cmd.accept) begin
            step_reg <= step_reg + 1'b1;
            if (s_x_pen_down) begin
                x_sum_reg   <= x_sum_reg + SUM_W'(s_x_sample);
                x_count_reg <= x_count_reg + 1'b1;
                if (s_y_pen_down) begin
                    y_sum_reg   <= y_sum_reg + SUM_W'(s_y_sample);
                    y_count_reg <= y_count_reg + 1'b1;
                end
            end
        end
    end

    // Operand selection for the shared divider.
    logic              axis_y;
    logic [MARGIN_W-1:0] near_m, far_m;
    logic [SIZE_W-1:0] size_sel;
    logic [SPAN_W-1:0] margin_sum, span;
    logic [DIV_N-1:0]  dividend;
    logic [DIV_M-1:0]  divisor;
    logic [DIV_N-1:0]  quotient;

    assign axis_y = (cmd.op == tsap_pkg::OP_PPX_Y) || (cmd.op == tsap_pkg::OP_AVG_Y) ||
                    (cmd.op == tsap_pkg::OP_SCL_Y);
    assign near_m   = axis_y ? y_top_reg    : x_left_reg;
    assign far_m    = axis_y ? y_bottom_reg : x_right_reg;
    assign size_sel = axis_y ? height_reg   : width_reg;

    always_comb begin
        margin_sum = SPAN_W'(near_m) + SPAN_W'(far_m);
        span = (margin_sum > SPAN_W'(full_scale_reg)) ? '0
                                                     : SPAN_W'(full_scale_reg) - margin_sum;
    end

    always_comb begin
        dividend = '0;
        divisor  = '0;
        unique case (cmd.op)
            tsap_pkg::OP_PPX_X, tsap_pkg::OP_PPX_Y: begin
                dividend = DIV_N'(span);
                divisor  = (size_sel == '0) ? DIV_M'(1) : DIV_M'(size_sel);
            end
            tsap_pkg::OP_AVG_X: begin
                dividend = DIV_N'(x_sum_reg);
                divisor  = DIV_M'(x_count_reg);
            end
            tsap_pkg::OP_AVG_Y: begin
                dividend = DIV_N'(y_sum_reg);
                divisor  = DIV_M'(y_count_reg);
            end
            tsap_pkg::OP_SCL_X, tsap_pkg::OP_SCL_Y: begin
                dividend = off_reg;
                divisor  = ppx_reg;
            end
            default: ;
        endcase
    end

    tsap_divider #(
        .DIVIDEND_W(DIV_N),
        .DIVISOR_W (DIV_M)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(dividend),
        .divisor (divisor),
        .quotient(quotient),
        .done    (status.div_done)
    );

    // Post-processing of each quotient as it is stored.
    logic [SIZE_W-1:0] pos_val;

    assign pos_val = (quotient > DIV_N'(size_sel)) ? '0
                                                   : size_sel - quotient[SIZE_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            unique case (cmd.op)
                tsap_pkg::OP_PPX_X, tsap_pkg::OP_PPX_Y: begin
                    ppx_reg <= (quotient == '0) ? DIV_M'(1) : quotient[DIV_M-1:0];
                end
                tsap_pkg::OP_AVG_X, tsap_pkg::OP_AVG_Y: begin
                    off_reg <= (quotient > DIV_N'(near_m)) ? quotient - DIV_N'(near_m) : '0;
                end
                tsap_pkg::OP_SCL_X: x_pos_reg <= pos_val;
                tsap_pkg::OP_SCL_Y: y_pos_reg <= pos_val;
                default: ;
            endcase
        end
    end

    // Output payload; the positions read as zero when nothing was found.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            found_reg <= status.found;
            x_out_reg <= status.found ? x_pos_reg : '0;
            y_out_reg <= status.found ? y_pos_reg : '0;
        end
    end

    assign m_found      = found_reg;
    assign m_x_position = x_out_reg;
    assign m_y_position = y_out_reg;

    `TSAP_ASSERT_IMPLY(a_ycnt_le_xcnt, aclk, aresetn, 1'b1, y_count_reg <= x_count_reg, "y count above x count")
    `TSAP_ASSERT_IMPLY(a_xcnt_le_step, aclk, aresetn, 1'b1, x_count_reg <= step_reg, "x count above step count")
    `TSAP_ASSERT_NEXT(a_clear_on_out, aclk, aresetn, cmd.out_load, step_reg == '0 && y_sum_reg == '0, "round state not cleared")
    `TSAP_ASSERT_IMPLY(a_ppx_nonzero, aclk, aresetn, cmd.div_start && (cmd.op == tsap_pkg::OP_SCL_X || cmd.op == tsap_pkg::OP_SCL_Y), ppx_reg != '0, "zero counts per pixel")

endmodule

// ===== sv/tsap_ctrl.sv =====
// Controller: accepts items, divides six times at a round end with Y found; drives the result handshake.
module tsap_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsap_pkg::dp_cmd_t    cmd,
    input  tsap_pkg::dp_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [tsap_pkg::OP_W-1:0] op_reg, op_next, op_succ;
    logic                      m_valid_reg, m_valid_next;
    logic                      accept, out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (op_reg)
            tsap_pkg::OP_PPX_X: op_succ = tsap_pkg::OP_AVG_X;
            tsap_pkg::OP_AVG_X: op_succ = tsap_pkg::OP_SCL_X;
            tsap_pkg::OP_SCL_X: op_succ = tsap_pkg::OP_PPX_Y;
            tsap_pkg::OP_PPX_Y: op_succ = tsap_pkg::OP_AVG_Y;
            tsap_pkg::OP_AVG_Y: op_succ = tsap_pkg::OP_SCL_Y;
            default:            op_succ = tsap_pkg::OP_PPX_X;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.accept    = accept;
        cmd.div_start = 1'b0;
        cmd.div_store = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.op        = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && status.round_end) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                // Sums now include the final item of the round.
                op_next    = tsap_pkg::OP_PPX_X;
                state_next = status.found ? S_START : S_OUT;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    if (op_reg == tsap_pkg::OP_SCL_Y) begin
                        state_next = S_OUT;
                    end else begin
                        op_next    = op_succ;
                        state_next = S_START;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= tsap_pkg::OP_PPX_X;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/touch_sample_average_to_pixel_top.sv =====
// Top level of the resistive touch averaging and pixel calibration block.
//
//  Channel  Ports                                                   Direction
//  s_       s_valid s_ready s_x_pen_down s_x_sample s_y_pen_down
//           s_y_sample                                              in
//  m_       m_valid m_ready m_found m_x_position m_y_position       out
//  cfg_     cfg_wr_en cfg_index cfg_wr_data                         in
//
// An item that does not end a round is taken while s_ready is high in the idle state.
// After the item that ends a round, the EVAL state runs; when a Y sample was found,
// six divisions follow on one bit-serial divider of DIV_N bits, DIV_N being
// max(ADC_BITS + clog2(MAX_SAMPLES + 1), 13); no item is taken before OUT is left.
// Input items keep flowing while a result waits; a round end stalls until the output
// register is free. Synchronous active-low reset restores the configuration defaults.
module touch_sample_average_to_pixel_top #(
    parameter int ADC_BITS    = tsap_pkg::ADC_BITS_DEF,
    parameter int MAX_SAMPLES = tsap_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tsap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsap_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_x_pen_down,
    input  logic [ADC_BITS-1:0]             s_x_sample,
    input  logic                            s_y_pen_down,
    input  logic [ADC_BITS-1:0]             s_y_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [tsap_pkg::SIZE_W-1:0]     m_x_position,
    output logic [tsap_pkg::SIZE_W-1:0]     m_y_position
);

    tsap_pkg::dp_cmd_t    cmd;
    tsap_pkg::dp_status_t status;

    tsap_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    tsap_datapath #(
        .ADC_BITS   (ADC_BITS),
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_x_pen_down(s_x_pen_down),
        .s_x_sample  (s_x_sample),
        .s_y_pen_down(s_y_pen_down),
        .s_y_sample  (s_y_sample),
        .cmd         (cmd),
        .status      (status),
        .m_found     (m_found),
        .m_x_position(m_x_position),
        .m_y_position(m_y_position)
    );

endmodule
